// ===== src/ggs_pkg.sv =====
`default_nettype none

package ggs_pkg;

	typedef enum logic [1:0] {
		REQ_GOAL     = 2'd0,
		REQ_CANCEL   = 2'd1,
		REQ_SAMPLE   = 2'd2,
		REQ_WATCHDOG = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		KIND_CMD      = 2'd0,
		KIND_STATUS   = 2'd1,
		KIND_FEEDBACK = 2'd2
	} res_kind_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED  = 2'd0,
		ST_SUCCEEDED = 2'd1,
		ST_ABORTED   = 2'd2,
		ST_CANCELED  = 2'd3
	} status_t;

	localparam logic [1:0] CFG_TOLERANCE   = 2'd0;
	localparam logic [1:0] CFG_STALL_SPEED = 2'd1;
	localparam logic [1:0] CFG_STALL_TIME  = 2'd2;

	localparam logic [22:0] TOL_RESET         = 23'd10000;
	localparam logic [30:0] STALL_SPEED_RESET = 31'd1;
	localparam logic [15:0] STALL_TIME_RESET  = 16'd100;

	localparam int GRACE_MS   = 1000;
	localparam int SILENCE_MS = 5000;

	localparam int MAX_RES = 3;

	typedef struct packed {
		req_kind_t          req_type;
		logic [31:0]        now_ms;
		logic [15:0]        goal_id;
		logic signed [23:0] goal_position;
		logic signed [23:0] goal_max_effort;
		logic [31:0]        sample_stamp_ms;
		logic signed [23:0] setpoint_pos;
		logic signed [23:0] measured_position;
		logic signed [31:0] measured_speed;
		logic signed [23:0] applied_effort;
	} req_t;

	typedef struct packed {
		res_kind_t          kind;
		logic [15:0]        goal;
		status_t            status;
		logic signed [23:0] cmd_position;
		logic signed [23:0] cmd_effort;
		logic signed [23:0] report_position;
		logic signed [23:0] report_effort;
		logic               reached;
		logic               stalled;
	} res_t;

	typedef struct packed {
		logic [1:0]         cnt;
		res_t [MAX_RES-1:0] r;
	} bundle_t;

endpackage

`default_nettype wire

// ===== src/ggs_core.sv =====
`default_nettype none

module ggs_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire ggs_pkg::req_t    req,
	input  wire logic             cfg_valid,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [30:0]      cfg_data,
	input  wire logic             bnd_ready,
	output logic                  bnd_valid,
	output ggs_pkg::bundle_t      bnd
);

	logic               s1_valid_q;
	ggs_pkg::req_t      item_s1;

	logic [22:0]        tol_q;
	logic [30:0]        spd_thr_q;
	logic [15:0]        stall_time_q;

	logic               active_q;
	logic               seen_q;
	logic [15:0]        goal_id_q;
	logic signed [23:0] tgt_pos_q;
	logic signed [23:0] tgt_eff_q;
	logic [31:0]        start_q;
	logic [31:0]        motion_q;
	logic signed [23:0] last_pos_q;
	logic [31:0]        stamp_q;

	logic signed [24:0] sp_err;
	logic signed [24:0] pos_err;
	logic [24:0]        sp_mag;
	logic [24:0]        pos_mag;
	logic [31:0]        spd_mag;
	logic [31:0]        dt_start;
	logic [31:0]        dt_motion;
	logic [31:0]        dt_stamp;
	logic               off_track;
	logic               grace_done;
	logic               on_target;
	logic               moving;
	logic               stall_hit;
	logic               silent;
	logic               id_match;
	logic               advance;
	logic               accept;
	ggs_pkg::bundle_t   bnd_d;

	function automatic ggs_pkg::res_t mk_res(
		input ggs_pkg::res_kind_t  kind,
		input logic [15:0]         goal,
		input ggs_pkg::status_t    st,
		input logic signed [23:0]  cpos,
		input logic signed [23:0]  ceff,
		input logic signed [23:0]  rpos,
		input logic signed [23:0]  reff,
		input logic                reached,
		input logic                stl
	);
		ggs_pkg::res_t r;
		r.kind            = kind;
		r.goal            = goal;
		r.status          = st;
		r.cmd_position    = cpos;
		r.cmd_effort      = ceff;
		r.report_position = rpos;
		r.report_effort   = reff;
		r.reached         = reached;
		r.stalled         = stl;
		return r;
	endfunction

	assign sp_err  = {item_s1.setpoint_pos[23], item_s1.setpoint_pos}
		- {tgt_pos_q[23], tgt_pos_q};
	assign pos_err = {item_s1.measured_position[23], item_s1.measured_position}
		- {tgt_pos_q[23], tgt_pos_q};
	assign sp_mag  = sp_err[24] ? 25'(-sp_err) : 25'(sp_err);
	assign pos_mag = pos_err[24] ? 25'(-pos_err) : 25'(pos_err);
	assign spd_mag = item_s1.measured_speed[31] ? 32'(-item_s1.measured_speed)
		: 32'(item_s1.measured_speed);

	assign dt_start  = item_s1.now_ms - start_q;
	assign dt_motion = item_s1.now_ms - motion_q;
	assign dt_stamp  = item_s1.now_ms - stamp_q;

	assign off_track  = sp_mag > {2'b00, tol_q};
	assign on_target  = pos_mag < {2'b00, tol_q};
	assign moving     = spd_mag > {1'b0, spd_thr_q};
	assign grace_done = $signed(dt_start) >= ggs_pkg::GRACE_MS;
	assign stall_hit  = ($signed(dt_motion) > $signed({16'd0, stall_time_q}))
		&& (tgt_eff_q != 24'sd0);
	assign silent     = !seen_q || ($signed(dt_stamp) > ggs_pkg::SILENCE_MS);
	assign id_match   = item_s1.goal_id == goal_id_q;

	always_comb begin
		bnd_d = '0;
		case (item_s1.req_type)
			ggs_pkg::REQ_GOAL: begin
				if (active_q) begin
					bnd_d.r[0] = mk_res(ggs_pkg::KIND_STATUS, goal_id_q, ggs_pkg::ST_CANCELED,
						'0, '0, '0, '0, 1'b0, 1'b0);
					bnd_d.r[1] = mk_res(ggs_pkg::KIND_STATUS, item_s1.goal_id,
						ggs_pkg::ST_ACCEPTED, '0, '0, '0, '0, 1'b0, 1'b0);
					bnd_d.r[2] = mk_res(ggs_pkg::KIND_CMD, item_s1.goal_id, ggs_pkg::ST_ACCEPTED,
						item_s1.goal_position, item_s1.goal_max_effort, '0, '0, 1'b0, 1'b0);
					bnd_d.cnt = 2'd3;
				end else begin
					bnd_d.r[0] = mk_res(ggs_pkg::KIND_STATUS, item_s1.goal_id,
						ggs_pkg::ST_ACCEPTED, '0, '0, '0, '0, 1'b0, 1'b0);
					bnd_d.r[1] = mk_res(ggs_pkg::KIND_CMD, item_s1.goal_id, ggs_pkg::ST_ACCEPTED,
						item_s1.goal_position, item_s1.goal_max_effort, '0, '0, 1'b0, 1'b0);
					bnd_d.cnt = 2'd2;
				end
			end
			ggs_pkg::REQ_CANCEL: begin
				if (id_match) begin
					if (seen_q) begin
						bnd_d.r[0] = mk_res(ggs_pkg::KIND_CMD, item_s1.goal_id,
							ggs_pkg::ST_ACCEPTED, last_pos_q, '0, '0, '0, 1'b0, 1'b0);
						bnd_d.r[1] = mk_res(ggs_pkg::KIND_STATUS, item_s1.goal_id,
							ggs_pkg::ST_CANCELED, '0, '0, '0, '0, 1'b0, 1'b0);
						bnd_d.cnt = active_q ? 2'd2 : 2'd1;
					end else if (active_q) begin
						bnd_d.r[0] = mk_res(ggs_pkg::KIND_STATUS, item_s1.goal_id,
							ggs_pkg::ST_CANCELED, '0, '0, '0, '0, 1'b0, 1'b0);
						bnd_d.cnt = 2'd1;
					end
				end
			end
			ggs_pkg::REQ_SAMPLE: begin
				if (active_q) begin
					if (off_track) begin
						if (grace_done) begin
							bnd_d.r[0] = mk_res(ggs_pkg::KIND_STATUS, goal_id_q,
								ggs_pkg::ST_CANCELED, '0, '0, '0, '0, 1'b0, 1'b0);
							bnd_d.cnt = 2'd1;
						end
					end else if (on_target) begin
						bnd_d.r[0] = mk_res(ggs_pkg::KIND_STATUS, goal_id_q, ggs_pkg::ST_SUCCEEDED,
							'0, '0, item_s1.measured_position, item_s1.applied_effort, 1'b1, 1'b0);
						bnd_d.cnt = 2'd1;
					end else if (!moving && stall_hit) begin
						bnd_d.r[0] = mk_res(ggs_pkg::KIND_STATUS, goal_id_q, ggs_pkg::ST_ABORTED,
							'0, '0, item_s1.measured_position, item_s1.applied_effort, 1'b0, 1'b1);
						bnd_d.cnt = 2'd1;
					end else begin
						bnd_d.r[0] = mk_res(ggs_pkg::KIND_FEEDBACK, goal_id_q, ggs_pkg::ST_ACCEPTED,
							'0, '0, item_s1.measured_position, item_s1.applied_effort, 1'b0, 1'b0);
						bnd_d.cnt = 2'd1;
					end
				end
			end
			ggs_pkg::REQ_WATCHDOG: begin
				if (active_q && silent) begin
					bnd_d.r[0] = mk_res(ggs_pkg::KIND_STATUS, goal_id_q, ggs_pkg::ST_ABORTED,
						'0, '0, '0, '0, 1'b0, 1'b0);
					bnd_d.cnt = 2'd1;
				end
			end
			default: begin
				bnd_d = '0;
			end
		endcase
	end

	assign advance   = s1_valid_q && (bnd_ready || bnd_d.cnt == 2'd0);
	assign req_stall = s1_valid_q && !advance;
	assign accept    = req_valid && !req_stall;
	assign bnd_valid = advance && bnd_d.cnt != 2'd0;
	assign bnd       = bnd_d;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			tol_q        <= ggs_pkg::TOL_RESET;
			spd_thr_q    <= ggs_pkg::STALL_SPEED_RESET;
			stall_time_q <= ggs_pkg::STALL_TIME_RESET;
			active_q     <= 1'b0;
			seen_q       <= 1'b0;
			goal_id_q    <= '0;
			tgt_pos_q    <= '0;
			tgt_eff_q    <= '0;
			start_q      <= '0;
			motion_q     <= '0;
			last_pos_q   <= '0;
			stamp_q      <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end

			if (cfg_valid) begin
				case (cfg_index)
					ggs_pkg::CFG_TOLERANCE:   tol_q        <= cfg_data[22:0];
					ggs_pkg::CFG_STALL_SPEED: spd_thr_q    <= cfg_data;
					ggs_pkg::CFG_STALL_TIME:  stall_time_q <= cfg_data[15:0];
					default: ;
				endcase
			end

			if (advance) begin
				case (item_s1.req_type)
					ggs_pkg::REQ_GOAL: begin
						goal_id_q <= item_s1.goal_id;
						tgt_pos_q <= item_s1.goal_position;
						tgt_eff_q <= item_s1.goal_max_effort;
						active_q  <= 1'b1;
						start_q   <= item_s1.now_ms;
						motion_q  <= item_s1.now_ms;
					end
					ggs_pkg::REQ_CANCEL: begin
						if (id_match) begin
							active_q <= 1'b0;
						end
					end
					ggs_pkg::REQ_SAMPLE: begin
						last_pos_q <= item_s1.measured_position;
						stamp_q    <= item_s1.sample_stamp_ms;
						seen_q     <= 1'b1;
						if (active_q) begin
							if (off_track) begin
								if (grace_done) begin
									active_q <= 1'b0;
								end
							end else if (on_target) begin
								active_q <= 1'b0;
							end else if (moving) begin
								motion_q <= item_s1.now_ms;
							end else if (stall_hit) begin
								active_q <= 1'b0;
							end
						end
					end
					ggs_pkg::REQ_WATCHDOG: begin
						if (silent) begin
							active_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/ggs_outq.sv =====
`default_nettype none

module ggs_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              bnd_valid,
	input  wire ggs_pkg::bundle_t  bnd,
	output logic                   bnd_ready,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output ggs_pkg::res_t          res,
	output logic                   res_last
);

	ggs_pkg::res_t [ggs_pkg::MAX_RES-1:0] ent_q;
	logic [1:0]                           rem_q;
	logic                                 pop;

	assign res_valid = rem_q != 2'd0;
	assign pop       = res_valid && !res_stall;
	assign bnd_ready = (rem_q == 2'd0) || (pop && rem_q == 2'd1);
	assign res       = ent_q[0];
	assign res_last  = rem_q == 2'd1;

	always_ff @(posedge clk) begin
		if (bnd_valid && bnd_ready) begin
			ent_q <= bnd.r;
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (bnd_valid && bnd_ready) begin
			rem_q <= bnd.cnt;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

// ===== src/gripper_goal_supervisor.sv =====
// An accepted event is registered, then evaluated; its result words are loaded into the
// output queue register, from which the first word is offered on the output.
// Throughput: one event per cycle unless the output stalls; an event with n result words
// (up to three) holds the output register until all are taken; further events wait.
// Reset: asynchronous, active low; clears goal state and the output queue, loads the
// configuration registers with their defaults.
`default_nettype none

module gripper_goal_supervisor (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic [31:0]        now_ms,
	input  wire logic [15:0]        goal_id,
	input  wire logic signed [23:0] goal_position,
	input  wire logic signed [23:0] goal_max_effort,
	input  wire logic [31:0]        sample_stamp_ms,
	input  wire logic signed [23:0] setpoint_pos,
	input  wire logic signed [23:0] measured_position,
	input  wire logic signed [31:0] measured_speed,
	input  wire logic signed [23:0] applied_effort,

	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [30:0]        cfg_data,

	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [1:0]              result_kind,
	output logic [15:0]             result_goal,
	output logic [1:0]              goal_status,
	output logic signed [23:0]      cmd_position,
	output logic signed [23:0]      cmd_effort,
	output logic signed [23:0]      report_position,
	output logic signed [23:0]      report_effort,
	output logic                    at_goal,
	output logic                    stalled,
	output logic                    last_result
);

	ggs_pkg::req_t    req;
	ggs_pkg::bundle_t bnd;
	logic             bnd_valid;
	logic             bnd_ready;
	ggs_pkg::res_t    res;

	assign req.req_type          = ggs_pkg::req_kind_t'(req_type);
	assign req.now_ms            = now_ms;
	assign req.goal_id           = goal_id;
	assign req.goal_position     = goal_position;
	assign req.goal_max_effort   = goal_max_effort;
	assign req.sample_stamp_ms   = sample_stamp_ms;
	assign req.setpoint_pos      = setpoint_pos;
	assign req.measured_position = measured_position;
	assign req.measured_speed    = measured_speed;
	assign req.applied_effort    = applied_effort;

	assign cfg_ready = 1'b1;

	ggs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bnd_ready (bnd_ready),
		.bnd_valid (bnd_valid),
		.bnd       (bnd)
	);

	ggs_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.bnd_valid (bnd_valid),
		.bnd       (bnd),
		.bnd_ready (bnd_ready),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.res_last  (last_result)
	);

	assign result_kind     = res.kind;
	assign result_goal     = res.goal;
	assign goal_status     = res.status;
	assign cmd_position    = res.cmd_position;
	assign cmd_effort      = res.cmd_effort;
	assign report_position = res.report_position;
	assign report_effort   = res.report_effort;
	assign at_goal         = res.reached;
	assign stalled         = res.stalled;

endmodule

`default_nettype wire

// ===== src/ggs_checker.sv =====
`default_nettype none

module ggs_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire logic [1:0]         result_kind,
	input wire logic [15:0]        result_goal,
	input wire logic [1:0]         goal_status,
	input wire logic signed [23:0] cmd_position,
	input wire logic signed [23:0] cmd_effort,
	input wire logic signed [23:0] report_position,
	input wire logic signed [23:0] report_effort,
	input wire logic               at_goal,
	input wire logic               stalled,
	input wire logic               last_result
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(result_kind) && $stable(result_goal)
			&& $stable(goal_status) && $stable(cmd_position) && $stable(cmd_effort)
			&& $stable(report_position) && $stable(report_effort) && $stable(at_goal)
			&& $stable(stalled) && $stable(last_result))
		else $error("output word changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> result_kind == ggs_pkg::KIND_CMD || result_kind == ggs_pkg::KIND_STATUS
			|| result_kind == ggs_pkg::KIND_FEEDBACK)
		else $error("undefined result kind");

	a_reached: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && at_goal |-> result_kind == ggs_pkg::KIND_STATUS
			&& goal_status == ggs_pkg::ST_SUCCEEDED && !stalled && last_result)
		else $error("reached flag outside a success status");

	a_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && stalled |-> result_kind == ggs_pkg::KIND_STATUS
			&& goal_status == ggs_pkg::ST_ABORTED && last_result)
		else $error("stall flag outside an abort status");

	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_kind == ggs_pkg::KIND_CMD |-> goal_status == ggs_pkg::ST_ACCEPTED
			&& report_position == 24'sd0 && report_effort == 24'sd0 && !at_goal)
		else $error("command word carries status fields");

endmodule

bind gripper_goal_supervisor ggs_checker u_ggs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (res_valid),
	.res_stall       (res_stall),
	.result_kind     (result_kind),
	.result_goal     (result_goal),
	.goal_status     (goal_status),
	.cmd_position    (cmd_position),
	.cmd_effort      (cmd_effort),
	.report_position (report_position),
	.report_effort   (report_effort),
	.at_goal         (at_goal),
	.stalled         (stalled),
	.last_result     (last_result)
);

`default_nettype wire
